/* hdl/rfft_pkg.sv */
// shared constants, types and the twiddle rom of the radix-2 fft
// no dependencies; every other file but rfft_ram and fft_bench_if refers to this package by scoped names
package rfft_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int LOG2_MAX   = $clog2(MAX_POINTS);
  localparam int ADDR_W     = LOG2_MAX;
  localparam int CNT_W      = LOG2_MAX + 1;
  localparam int HALF_ROM   = MAX_POINTS / 2;
  localparam int TW_ADDR_W  = LOG2_MAX - 1;
  localparam int TW_W       = 18;
  localparam int DATA_W     = 32;
  localparam int WORD_W     = 2 * DATA_W;
  localparam int LG_W       = 4;
  localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
  localparam logic [LG_W-1:0] LG_RESET = LG_W'(10);

  // register indexes of the configuration port
  localparam logic CFG_LOG2_POINTS = 1'b0;
  localparam logic CFG_DIRECTION   = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_PAD,
    ST_REV_RA,
    ST_REV_RB,
    ST_REV_WA,
    ST_REV_WB,
    ST_BF_RA,
    ST_BF_RB,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB,
    ST_SC_RD,
    ST_SC_WR
  } fft_state_t;

  typedef struct packed {
    logic tw_en;
    logic mul_en;
    logic sum_en;
  } bf_ctl_t;

  typedef logic signed [TW_W-1:0] tw_rom_t [HALF_ROM];

  // integer taylor series of cos or sin, q29 products, rounded to q16
  function automatic tw_rom_t tw_build(input bit want_sin);
    tw_rom_t rom;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] c;
    logic signed [63:0] s;
    logic signed [63:0] t;
    logic signed [63:0] v;
    for (int k = 0; k < HALF_ROM; k++) begin
      x = (64'(k) * TWO_PI_Q29 + 64'(MAX_POINTS / 2)) / 64'(MAX_POINTS);
      term = 64'd1 << 29;
      c = $signed(term);
      s = 64'sd0;
      for (int n = 1; n < 30; n++) begin
        term = ((term * x) >> 29) / 64'(n);
        t = (((n >> 1) & 1) != 0) ? -$signed(term) : $signed(term);
        if ((n & 1) != 0) s = s + t;
        else c = c + t;
      end
      v = want_sin ? s : c;
      v = (v + 64'sd4096) >>> 13;
      rom[k] = TW_W'(v);
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_COS = tw_build(1'b0);
  localparam tw_rom_t TW_SIN = tw_build(1'b1);

endpackage

/* hdl/rfft_chan_if.sv */
// valid/ready channels of the fft: command words in, point words out
// depends on rfft_pkg for the data width
interface rfft_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] sample_real;
  logic [15:0] sample_imag;
  logic        frame_end;

  modport source (output valid, command, sample_real, sample_imag, frame_end, input ready);
  modport sink (input valid, command, sample_real, sample_imag, frame_end, output ready);
endinterface

interface rfft_out_if;
  logic                           valid;
  logic                           ready;
  logic [rfft_pkg::DATA_W-1:0]    point_real;
  logic [rfft_pkg::DATA_W-1:0]    point_imag;
  logic                           final_point;

  modport source (output valid, point_real, point_imag, final_point, input ready);
  modport sink (input valid, point_real, point_imag, final_point, output ready);
endinterface

/* hdl/radix2_fft_1d.sv */
// in-place radix-2 decimation-in-time fft over a 1024 x 64 point ram
// depends on rfft_pkg, rfft_chan_if, rfft_ram and rfft_bfly
//
//   port   dir   word                                        accepted when
//   req    in    command, sample_real/imag, frame_end        valid && ready
//   rsp    out   point_real/imag, final_point                valid && ready
//   cfg    in    cfg_index, cfg_data                         cfg_we
//
// a load is written to the ram when accepted; a read goes through one ram read, then the output register
// frame_end runs pad, reorder (swapping each pair of bit-reversed addresses once),
// n/2*log2(n) butterflies (read a and b, multiply, sum, write top and bottom), and
// 1/n scaling only when direction is set; all share the single ram read and write port
// after reset a clearing pass writes zeros to all 1024 words with req.ready low
// req is held off while a read word waits in the output register
module radix2_fft_1d (
  input  logic                          clk,
  input  logic                          rst,
  rfft_in_if.sink                       req,
  rfft_out_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rfft_pkg::LG_W-1:0]     cfg_data
);

  rfft_pkg::fft_state_t state;
  rfft_pkg::fft_state_t state_next;

  logic [rfft_pkg::LG_W-1:0]   log2_points;
  logic                        direction;
  logic [rfft_pkg::LG_W-1:0]   lg_f;
  logic                        dir_f;
  logic [rfft_pkg::CNT_W-1:0]  load_position;
  logic [rfft_pkg::ADDR_W-1:0] read_position;
  logic [rfft_pkg::CNT_W-1:0]  idx;
  logic [rfft_pkg::ADDR_W-2:0] bidx;
  logic [rfft_pkg::LG_W-1:0]   stage;
  logic [rfft_pkg::WORD_W-1:0] hold;
  logic                        out_valid;
  logic [rfft_pkg::DATA_W-1:0] out_re;
  logic [rfft_pkg::DATA_W-1:0] out_im;
  logic                        out_final;
  logic                        rd_final;

  logic                        ram_we;
  logic [rfft_pkg::ADDR_W-1:0] ram_waddr;
  logic [rfft_pkg::WORD_W-1:0] ram_wdata;
  logic [rfft_pkg::ADDR_W-1:0] ram_raddr;
  logic [rfft_pkg::WORD_W-1:0] ram_rdata;

  rfft_pkg::bf_ctl_t           bf_ctl;
  logic [rfft_pkg::WORD_W-1:0] top_word;
  logic [rfft_pkg::WORD_W-1:0] bot_word;

  logic [rfft_pkg::LG_W-1:0]   lg_live;
  logic [rfft_pkg::CNT_W-1:0]  n_live;
  logic [rfft_pkg::CNT_W-1:0]  n_f;
  logic                        fire;
  logic                        room;
  logic [rfft_pkg::CNT_W-1:0]  load_new;
  logic [rfft_pkg::ADDR_W-1:0] rd_pos;
  logic [rfft_pkg::ADDR_W-1:0] rev_full;
  logic [rfft_pkg::ADDR_W-1:0] rev_idx;
  logic [rfft_pkg::ADDR_W-1:0] bx;
  logic [rfft_pkg::ADDR_W-1:0] bf_m;
  logic [rfft_pkg::ADDR_W-1:0] bf_i;
  logic [rfft_pkg::ADDR_W-1:0] bf_j;
  logic [rfft_pkg::TW_ADDR_W-1:0] tw_index;
  logic                        last_bf;
  logic                        last_stage;
  logic signed [rfft_pkg::DATA_W:0] sc_re;
  logic signed [rfft_pkg::DATA_W:0] sc_im;
  logic signed [rfft_pkg::DATA_W:0] sc_half;

  // log2 of the frame size clamped to 1 .. LOG2_MAX
  always_comb begin
    if (log2_points < rfft_pkg::LG_W'(1)) begin
      lg_live = rfft_pkg::LG_W'(1);
    end else if (log2_points > rfft_pkg::LG_W'(rfft_pkg::LOG2_MAX)) begin
      lg_live = rfft_pkg::LG_W'(rfft_pkg::LOG2_MAX);
    end else begin
      lg_live = log2_points;
    end
  end

  assign n_live   = rfft_pkg::CNT_W'(1) << lg_live;
  assign n_f      = rfft_pkg::CNT_W'(1) << lg_f;
  assign fire     = req.valid && req.ready;
  assign room     = load_position < n_live;
  assign load_new = room ? load_position + rfft_pkg::CNT_W'(1) : load_position;
  assign rd_pos   = (rfft_pkg::CNT_W'(read_position) >= n_live) ? '0 : read_position;
  assign rd_final = rfft_pkg::CNT_W'(rd_pos) == n_live - rfft_pkg::CNT_W'(1);

  always_comb begin
    for (int b = 0; b < rfft_pkg::ADDR_W; b++) begin
      rev_full[b] = idx[rfft_pkg::ADDR_W-1-b];
    end
  end
  assign rev_idx = rev_full >> (rfft_pkg::LG_W'(rfft_pkg::ADDR_W) - lg_f);

  // butterfly number -> upper and lower addresses and twiddle index
  assign bx    = rfft_pkg::ADDR_W'(bidx);
  assign bf_m  = bx & ((rfft_pkg::ADDR_W'(1) << stage) - rfft_pkg::ADDR_W'(1));
  assign bf_i  = ((bx >> stage) << (stage + rfft_pkg::LG_W'(1))) | bf_m;
  assign bf_j  = bf_i | (rfft_pkg::ADDR_W'(1) << stage);
  assign tw_index = rfft_pkg::TW_ADDR_W'(bf_m << (rfft_pkg::LG_W'(rfft_pkg::TW_ADDR_W) - stage));
  assign last_bf    = bidx == rfft_pkg::TW_ADDR_W'((n_f >> 1) - rfft_pkg::CNT_W'(1));
  assign last_stage = stage == lg_f - rfft_pkg::LG_W'(1);

  // 1/n scaling, rounded
  assign sc_half = (rfft_pkg::DATA_W+1)'(1) <<< (lg_f - rfft_pkg::LG_W'(1));
  assign sc_re = ((rfft_pkg::DATA_W+1)'($signed(ram_rdata[rfft_pkg::WORD_W-1:rfft_pkg::DATA_W]))
                  + sc_half) >>> lg_f;
  assign sc_im = ((rfft_pkg::DATA_W+1)'($signed(ram_rdata[rfft_pkg::DATA_W-1:0]))
                  + sc_half) >>> lg_f;

  always_comb begin
    state_next = state;
    unique case (state)
      rfft_pkg::ST_CLEAR: begin
        if (idx == rfft_pkg::CNT_W'(rfft_pkg::MAX_POINTS - 1)) state_next = rfft_pkg::ST_IDLE;
      end
      rfft_pkg::ST_IDLE: begin
        if (fire && req.command) state_next = rfft_pkg::ST_RD_WAIT;
        else if (fire && req.frame_end) state_next = rfft_pkg::ST_PAD;
      end
      rfft_pkg::ST_RD_WAIT: state_next = rfft_pkg::ST_IDLE;
      rfft_pkg::ST_PAD: begin
        if (idx >= n_f) state_next = rfft_pkg::ST_REV_RA;
      end
      rfft_pkg::ST_REV_RA: begin
        if (idx >= n_f) state_next = rfft_pkg::ST_BF_RA;
        else if (rfft_pkg::CNT_W'(rev_idx) > idx) state_next = rfft_pkg::ST_REV_RB;
      end
      rfft_pkg::ST_REV_RB: state_next = rfft_pkg::ST_REV_WA;
      rfft_pkg::ST_REV_WA: state_next = rfft_pkg::ST_REV_WB;
      rfft_pkg::ST_REV_WB: state_next = rfft_pkg::ST_REV_RA;
      rfft_pkg::ST_BF_RA:  state_next = rfft_pkg::ST_BF_RB;
      rfft_pkg::ST_BF_RB:  state_next = rfft_pkg::ST_BF_MUL;
      rfft_pkg::ST_BF_MUL: state_next = rfft_pkg::ST_BF_SUM;
      rfft_pkg::ST_BF_SUM: state_next = rfft_pkg::ST_BF_WA;
      rfft_pkg::ST_BF_WA:  state_next = rfft_pkg::ST_BF_WB;
      rfft_pkg::ST_BF_WB: begin
        if (!(last_bf && last_stage)) state_next = rfft_pkg::ST_BF_RA;
        else if (dir_f) state_next = rfft_pkg::ST_SC_RD;
        else state_next = rfft_pkg::ST_IDLE;
      end
      rfft_pkg::ST_SC_RD: begin
        if (idx >= n_f) state_next = rfft_pkg::ST_IDLE;
        else state_next = rfft_pkg::ST_SC_WR;
      end
      rfft_pkg::ST_SC_WR: state_next = rfft_pkg::ST_SC_RD;
      default: state_next = rfft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[rfft_pkg::ADDR_W-1:0];
    ram_wdata = '0;
    ram_raddr = idx[rfft_pkg::ADDR_W-1:0];
    bf_ctl    = '0;
    req.ready = 1'b0;
    unique case (state)
      rfft_pkg::ST_CLEAR: ram_we = 1'b1;
      rfft_pkg::ST_IDLE: begin
        req.ready = !out_valid || rsp.ready;
        ram_raddr = rd_pos;
        ram_waddr = load_position[rfft_pkg::ADDR_W-1:0];
        ram_wdata = {{16{req.sample_real[15]}}, req.sample_real,
                     {16{req.sample_imag[15]}}, req.sample_imag};
        ram_we    = fire && !req.command && room;
      end
      rfft_pkg::ST_PAD: ram_we = idx < n_f;
      rfft_pkg::ST_REV_RB: ram_raddr = rev_idx;
      rfft_pkg::ST_REV_WA: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      rfft_pkg::ST_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = rev_idx;
        ram_wdata = hold;
      end
      rfft_pkg::ST_BF_RA: begin
        ram_raddr = bf_i;
        bf_ctl.tw_en = 1'b1;
      end
      rfft_pkg::ST_BF_RB:  ram_raddr = bf_j;
      rfft_pkg::ST_BF_MUL: bf_ctl.mul_en = 1'b1;
      rfft_pkg::ST_BF_SUM: bf_ctl.sum_en = 1'b1;
      rfft_pkg::ST_BF_WA: begin
        ram_we    = 1'b1;
        ram_waddr = bf_i;
        ram_wdata = top_word;
      end
      rfft_pkg::ST_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = bf_j;
        ram_wdata = bot_word;
      end
      rfft_pkg::ST_SC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {sc_re[rfft_pkg::DATA_W-1:0], sc_im[rfft_pkg::DATA_W-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rfft_pkg::ST_CLEAR;
      log2_points   <= rfft_pkg::LG_RESET;
      direction     <= 1'b0;
      lg_f          <= rfft_pkg::LG_RESET;
      dir_f         <= 1'b0;
      load_position <= '0;
      read_position <= '0;
      idx           <= '0;
      bidx          <= '0;
      stage         <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          rfft_pkg::CFG_LOG2_POINTS: log2_points <= cfg_data;
          rfft_pkg::CFG_DIRECTION:   direction <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == rfft_pkg::ST_RD_WAIT) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rfft_pkg::ST_CLEAR: idx <= idx + rfft_pkg::CNT_W'(1);
        rfft_pkg::ST_IDLE: begin
          if (fire && req.command) begin
            read_position <= rd_final ? '0 : rd_pos + rfft_pkg::ADDR_W'(1);
            out_final     <= rd_final;
          end else if (fire) begin
            load_position <= req.frame_end ? '0 : load_new;
            if (req.frame_end) begin
              idx           <= load_new;
              lg_f          <= lg_live;
              dir_f         <= direction;
              read_position <= '0;
            end
          end
        end
        rfft_pkg::ST_RD_WAIT: begin
          out_re    <= ram_rdata[rfft_pkg::WORD_W-1:rfft_pkg::DATA_W];
          out_im    <= ram_rdata[rfft_pkg::DATA_W-1:0];
        end
        rfft_pkg::ST_PAD: begin
          idx <= (idx < n_f) ? idx + rfft_pkg::CNT_W'(1) : '0;
        end
        rfft_pkg::ST_REV_RA: begin
          if (idx >= n_f) begin
            bidx  <= '0;
            stage <= '0;
          end else if (!(rfft_pkg::CNT_W'(rev_idx) > idx)) begin
            idx <= idx + rfft_pkg::CNT_W'(1);
          end
        end
        rfft_pkg::ST_REV_RB: hold <= ram_rdata;
        rfft_pkg::ST_REV_WB: idx <= idx + rfft_pkg::CNT_W'(1);
        rfft_pkg::ST_BF_RB:  hold <= ram_rdata;
        rfft_pkg::ST_BF_WB: begin
          idx <= '0;
          if (last_bf) begin
            bidx  <= '0;
            stage <= stage + rfft_pkg::LG_W'(1);
          end else begin
            bidx <= bidx + rfft_pkg::TW_ADDR_W'(1);
          end
        end
        rfft_pkg::ST_SC_WR: idx <= idx + rfft_pkg::CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.point_real  = out_re;
  assign rsp.point_imag  = out_im;
  assign rsp.final_point = out_final;

  rfft_ram #(
    .WIDTH(rfft_pkg::WORD_W),
    .DEPTH(rfft_pkg::MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rfft_bfly u_bfly (
    .clk      (clk),
    .ctl      (bf_ctl),
    .tw_index (tw_index),
    .direction(dir_f),
    .a_word   (hold),
    .b_word   (ram_rdata),
    .top_word (top_word),
    .bot_word (bot_word)
  );

endmodule

/* hdl/rfft_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rfft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rfft_bfly.sv */
// butterfly datapath: twiddle lookup, four products, rounding, add and subtract
// depends on rfft_pkg for widths, the control struct and the twiddle rom
module rfft_bfly (
  input  logic                             clk,
  input  rfft_pkg::bf_ctl_t                ctl,
  input  logic [rfft_pkg::TW_ADDR_W-1:0]   tw_index,
  input  logic                             direction,
  input  logic [rfft_pkg::WORD_W-1:0]      a_word,
  input  logic [rfft_pkg::WORD_W-1:0]      b_word,
  output logic [rfft_pkg::WORD_W-1:0]      top_word,
  output logic [rfft_pkg::WORD_W-1:0]      bot_word
);

  logic signed [rfft_pkg::TW_W-1:0]   wr;
  logic signed [rfft_pkg::TW_W-1:0]   wi;
  logic signed [rfft_pkg::DATA_W-1:0] b_re;
  logic signed [rfft_pkg::DATA_W-1:0] b_im;
  logic signed [rfft_pkg::DATA_W-1:0] a_re;
  logic signed [rfft_pkg::DATA_W-1:0] a_im;
  logic signed [49:0] p_rr;
  logic signed [49:0] p_ii;
  logic signed [49:0] p_ri;
  logic signed [49:0] p_ir;
  logic signed [50:0] sum_re;
  logic signed [50:0] sum_im;
  logic [rfft_pkg::DATA_W-1:0] tr;
  logic [rfft_pkg::DATA_W-1:0] ti;

  assign b_re = b_word[rfft_pkg::WORD_W-1:rfft_pkg::DATA_W];
  assign b_im = b_word[rfft_pkg::DATA_W-1:0];
  assign a_re = a_word[rfft_pkg::WORD_W-1:rfft_pkg::DATA_W];
  assign a_im = a_word[rfft_pkg::DATA_W-1:0];

  // t = w * b, each part rounded to nearest with floor
  assign sum_re = 51'(p_rr) - 51'(p_ii) + 51'sd32768;
  assign sum_im = 51'(p_ri) + 51'(p_ir) + 51'sd32768;

  always_ff @(posedge clk) begin
    if (ctl.tw_en) begin
      wr <= rfft_pkg::TW_COS[tw_index];
      wi <= direction ? rfft_pkg::TW_SIN[tw_index] : -rfft_pkg::TW_SIN[tw_index];
    end
    if (ctl.mul_en) begin
      p_rr <= wr * b_re;
      p_ii <= wi * b_im;
      p_ri <= wr * b_im;
      p_ir <= wi * b_re;
    end
    if (ctl.sum_en) begin
      tr <= sum_re[47:16];
      ti <= sum_im[47:16];
    end
  end

  assign top_word = {a_re + tr, a_im + ti};
  assign bot_word = {a_re - tr, a_im - ti};

endmodule

/* bench/fft_bench_if.sv */
`timescale 1ns / 100ps
// bench-side copies of the fft channels are not needed; this file holds the
// word structs shared by the bench; no dependencies
package fft_bench_pkg;
  typedef struct packed {
    logic        command;
    logic [15:0] sample_real;
    logic [15:0] sample_imag;
    logic        frame_end;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0] point_real;
    logic [31:0] point_imag;
    logic        final_point;
  } point_word_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;
endpackage

/* bench/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench of radix2_fft_1d: load/transform/read frames checked
// against a bit-exact fft predictor; depends on rfft_pkg, rfft_chan_if, fft_bench_pkg
module testbench;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [rfft_pkg::LG_W-1:0] cfg_data;

  rfft_in_if  req ();
  rfft_out_if rsp ();

  radix2_fft_1d u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint pt_re [rfft_pkg::MAX_POINTS];
  longint pt_im [rfft_pkg::MAX_POINTS];
  int unsigned load_pos, read_pos;
  int unsigned frame_lg_cfg, dir_cfg;

  fft_bench_pkg::cmd_word_t   cmd_queue [$];
  fft_bench_pkg::point_word_t point_queue [$];

  int mismatches = 0;
  int fails = 0;
  int idle_cycles = 0;
  int hold_off;
  int rx_words;
  int burst_left, gap_left;
  bit cfg_busy;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_32(longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  function automatic int unsigned frame_lg();
    int unsigned l;
    l = frame_lg_cfg;
    if (l < 1) l = 1;
    if (l > rfft_pkg::LOG2_MAX) l = rfft_pkg::LOG2_MAX;
    return l;
  endfunction

  task automatic run_fft();
    int unsigned lg, n, r, k, j, h, stride;
    longint wr, wi, tr, ti, tmp, half;
    lg = frame_lg();
    n = 1 << lg;
    for (int unsigned i = 0; i < n; i++) begin
      r = 0;
      for (int unsigned b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
      if (r > i) begin
        tmp = pt_re[i]; pt_re[i] = pt_re[r]; pt_re[r] = tmp;
        tmp = pt_im[i]; pt_im[i] = pt_im[r]; pt_im[r] = tmp;
      end
    end
    for (h = 1; h < n; h <<= 1) begin
      stride = rfft_pkg::MAX_POINTS / (2 * h);
      for (int unsigned m = 0; m < h; m++) begin
        k = (m * stride) % rfft_pkg::HALF_ROM;
        wr = longint'(rfft_pkg::TW_COS[k]);
        wi = dir_cfg ? longint'(rfft_pkg::TW_SIN[k]) : -longint'(rfft_pkg::TW_SIN[k]);
        for (int unsigned i = m; i + h < n; i += 2 * h) begin
          j = i + h;
          tr = floor_shift(wr * pt_re[j] - wi * pt_im[j] + 32768, 16);
          ti = floor_shift(wr * pt_im[j] + wi * pt_re[j] + 32768, 16);
          pt_re[j] = wrap_32(pt_re[i] - tr);
          pt_im[j] = wrap_32(pt_im[i] - ti);
          pt_re[i] = wrap_32(pt_re[i] + tr);
          pt_im[i] = wrap_32(pt_im[i] + ti);
        end
      end
    end
    if (dir_cfg) begin
      half = longint'(1) << (lg - 1);
      for (int unsigned i = 0; i < n; i++) begin
        pt_re[i] = floor_shift(pt_re[i] + half, lg);
        pt_im[i] = floor_shift(pt_im[i] + half, lg);
      end
    end
  endtask

  // apply one accepted command word to the predictor
  task automatic predict_word(fft_bench_pkg::cmd_word_t w);
    int unsigned n, p;
    fft_bench_pkg::point_word_t pw;
    n = 1 << frame_lg();
    if (w.command == fft_bench_pkg::CMD_READ) begin
      p = read_pos;
      if (p >= n) p = 0;
      pw.point_real = pt_re[p][31:0];
      pw.point_imag = pt_im[p][31:0];
      pw.final_point = (p == n - 1);
      point_queue.push_back(pw);
      read_pos = (p == n - 1) ? 0 : p + 1;
    end else begin
      if (load_pos < n) begin
        pt_re[load_pos] = longint'(signed'(w.sample_real));
        pt_im[load_pos] = longint'(signed'(w.sample_imag));
        load_pos++;
      end
      if (w.frame_end) begin
        for (int unsigned q = load_pos; q < n; q++) begin
          pt_re[q] = 0;
          pt_im[q] = 0;
        end
        run_fft();
        load_pos = 0;
        read_pos = 0;
      end
    end
  endtask

  function automatic fft_bench_pkg::cmd_word_t mk_load(logic [15:0] re, logic [15:0] im,
                                                       logic fe);
    fft_bench_pkg::cmd_word_t w;
    w.command = fft_bench_pkg::CMD_LOAD;
    w.sample_real = re;
    w.sample_imag = im;
    w.frame_end = fe;
    return w;
  endfunction

  function automatic fft_bench_pkg::cmd_word_t mk_read();
    fft_bench_pkg::cmd_word_t w;
    w.command = fft_bench_pkg::CMD_READ;
    w.sample_real = 16'($urandom);
    w.sample_imag = 16'($urandom);
    w.frame_end = 1'($urandom);
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.command <= fft_bench_pkg::CMD_LOAD;
      req.sample_real <= '0;
      req.sample_imag <= '0;
      req.frame_end <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!req.valid || req.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req.valid <= 1'b0;
      end else if (cmd_queue.size() > 0 && !cfg_busy) begin
        fft_bench_pkg::cmd_word_t w;
        w = cmd_queue.pop_front();
        req.valid <= 1'b1;
        req.command <= w.command;
        req.sample_real <= w.sample_real;
        req.sample_imag <= w.sample_imag;
        req.frame_end <= w.frame_end;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus long hold-off windows
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_off <= 0;
      rx_words <= 0;
    end else begin
      if (rsp.valid && rsp.ready) rx_words <= rx_words + 1;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp.ready <= 1'b0;
      end else if (rsp.valid && rsp.ready && (rx_words % 150) == 40) begin
        // long hold-off while the sender keeps offering reads
        hold_off <= $urandom_range(200, 600);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor: predict accepted commands, check accepted points
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        fft_bench_pkg::cmd_word_t w;
        w.command = req.command;
        w.sample_real = req.sample_real;
        w.sample_imag = req.sample_imag;
        w.frame_end = req.frame_end;
        predict_word(w);
      end
      if (rsp.valid && rsp.ready) begin
        if (point_queue.size() == 0) begin
          fails++;
          if (mismatches < 10) $display("unexpected point word %h %h %b",
            rsp.point_real, rsp.point_imag, rsp.final_point);
          mismatches++;
        end else begin
          fft_bench_pkg::point_word_t e;
          e = point_queue.pop_front();
          if (e.point_real !== rsp.point_real || e.point_imag !== rsp.point_imag ||
              e.final_point !== rsp.final_point) begin
            fails++;
            if (mismatches < 10)
              $display("point mismatch: expected %h %h %b got %h %h %b",
                e.point_real, e.point_imag, e.final_point,
                rsp.point_real, rsp.point_imag, rsp.final_point);
            mismatches++;
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      // pad, reorder, butterflies and scaling of a full frame, with margin
      if (idle_cycles > 400000) begin
        $display("radix2_fft_1d verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [rfft_pkg::LG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rfft_pkg::CFG_LOG2_POINTS) frame_lg_cfg = val;
    else dir_cfg = val[0];
  endtask

  // wait for the block to drain, then let a transform in flight complete
  task automatic drain();
    while (cmd_queue.size() > 0 || req.valid || point_queue.size() > 0) @(posedge clk);
    cfg_busy = 1'b1;
    repeat (70000) @(posedge clk);
  endtask

  task automatic queue_frame(int unsigned nload, bit with_reads, int unsigned nread);
    for (int unsigned i = 0; i < nload; i++)
      cmd_queue.push_back(mk_load(rand_sample(), rand_sample(), i == nload - 1));
    if (with_reads)
      for (int unsigned i = 0; i < nread; i++) cmd_queue.push_back(mk_read());
  endtask

  initial begin
    int unsigned lg, n, items;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = rfft_pkg::CFG_LOG2_POINTS;
    cfg_data = '0;
    cfg_busy = 1'b1;
    load_pos = 0;
    read_pos = 0;
    frame_lg_cfg = 10;
    dir_cfg = 0;
    for (int i = 0; i < rfft_pkg::MAX_POINTS; i++) begin
      pt_re[i] = 0;
      pt_im[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: read before any transform, extremes, 4 points
    write_reg(rfft_pkg::CFG_LOG2_POINTS, 4'd2);
    write_reg(rfft_pkg::CFG_DIRECTION, 1'b0);
    cfg_busy = 1'b0;
    cmd_queue.push_back(mk_read());
    cmd_queue.push_back(mk_load(16'h7fff, 16'h8000, 1'b0));
    cmd_queue.push_back(mk_load(16'h8000, 16'h7fff, 1'b0));
    cmd_queue.push_back(mk_load(16'hffff, 16'h0001, 1'b0));
    cmd_queue.push_back(mk_load(16'h7fff, 16'h7fff, 1'b0));
    // load beyond the frame is dropped, frame_end still transforms
    cmd_queue.push_back(mk_load(16'h1234, 16'h4321, 1'b1));
    for (int i = 0; i < 6; i++) cmd_queue.push_back(mk_read());  // wraps
    drain();
    write_reg(rfft_pkg::CFG_DIRECTION, 1'b1);
    write_reg(rfft_pkg::CFG_LOG2_POINTS, 4'd0);  // clamps to 2 points
    cfg_busy = 1'b0;
    cmd_queue.push_back(mk_load(16'h8000, 16'h8000, 1'b1));  // padded
    for (int i = 0; i < 3; i++) cmd_queue.push_back(mk_read());
    cmd_queue.push_back(mk_read());
    drain();
    write_reg(rfft_pkg::CFG_LOG2_POINTS, 4'd15);  // clamps to 1024
    write_reg(rfft_pkg::CFG_DIRECTION, 1'b0);
    cfg_busy = 1'b0;
    cmd_queue.push_back(mk_load(16'h7fff, 16'h8000, 1'b1));
    for (int i = 0; i < 4; i++) cmd_queue.push_back(mk_read());
    drain();
    // size reduced while read position is past the new frame
    write_reg(rfft_pkg::CFG_LOG2_POINTS, 4'd1);
    cfg_busy = 1'b0;
    cmd_queue.push_back(mk_read());
    drain();

    // random phases, mostly small frames, a few at 1024
    items = 0;
    while (items < 650) begin
      write_reg(rfft_pkg::CFG_LOG2_POINTS, ($urandom_range(0, 12) == 0) ? 4'd10
        : 4'($urandom_range(1, 5)));
      write_reg(rfft_pkg::CFG_DIRECTION, 1'($urandom));
      cfg_busy = 1'b0;
      lg = frame_lg();
      n = 1 << lg;
      for (int f = 0; f < 3 && items < 650; f++) begin
        if (n > 64 || $urandom_range(0, 9) == 0) begin
          // noise: short frame, stray reads
          queue_frame($urandom_range(1, 4), 1, $urandom_range(1, 5));
          items += 8;
        end else begin
          int unsigned nl;
          nl = $urandom_range(1, n + 2);
          queue_frame(nl, 1, n + $urandom_range(0, 2));
          items += nl + n;
        end
      end
      drain();
    end

    if (fails == 0 && point_queue.size() == 0) begin
      $display("radix2_fft_1d verification clean");
    end else begin
      $display("radix2_fft_1d verification failed");
    end
    $finish;
  end
endmodule
